### hw/rtl/rbw_pkg.sv
// Shared types, constants and the colour lookup for the rainbow pattern generator.
`default_nettype none
package rbw_pkg;

  localparam int DefMaxBulbs = 64;

  localparam int ModeW  = 4;
  localparam int CountW = 7;
  localparam int IdxW   = 6;
  localparam int LevelW = 4;
  localparam int PhaseW = 6;
  localparam int DivW   = 12;
  localparam int StepW  = 4;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 7;
  localparam int InDataW  = 8;
  localparam int OutDataW = 24;

  localparam logic [CfgIdxW-1:0] CfgRegMode  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgRegCount = 1'b1;

  localparam logic [ModeW-1:0]  ModeCount    = 4'd12;
  localparam logic [CountW-1:0] CountReset   = 7'd50;
  localparam logic [PhaseW-1:0] RampCycle    = 6'd32;
  localparam logic [PhaseW-1:0] WheelCycle   = 6'd48;
  localparam logic [StepW-1:0]  DivLastStep  = 4'(DivW - 1);

  // scheme codes (mode modulo four)
  localparam logic [1:0] SchRedGreen  = 2'd0;
  localparam logic [1:0] SchGreenBlue = 2'd1;
  localparam logic [1:0] SchBlueRed   = 2'd2;
  localparam logic [1:0] SchWheel     = 2'd3;

  // variant codes (mode divided by four)
  localparam logic [1:0] VarOffset = 2'd0;
  localparam logic [1:0] VarSpread = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_LOAD,
    ST_SEND
  } rbw_state_e;

  typedef struct packed {
    logic frame_start;
    logic adv_phase;
    logic div_init;
    logic div_step;
    logic load_out;
    logic next_bulb;
  } rbw_cmd_t;

  typedef struct packed {
    logic spread;
    logic n_zero;
    logic last;
    logic div_done;
  } rbw_sts_t;

  typedef struct packed {
    logic [LevelW-1:0] r;
    logic [LevelW-1:0] g;
    logic [LevelW-1:0] b;
  } rbw_rgb_t;

  function automatic rbw_rgb_t rbw_colour(input logic [1:0] scheme,
                                          input logic [PhaseW-1:0] pos);
    rbw_rgb_t c;
    logic [1:0] seg;
    logic [LevelW-1:0] up;
    logic [LevelW-1:0] down;
    seg  = pos[5:4];
    up   = pos[3:0];
    down = ~pos[3:0];
    c    = '0;
    case (scheme)
      SchRedGreen: begin
        if (seg == 2'd0) begin
          c.r = down; c.g = up;
        end else begin
          c.r = up; c.g = down;
        end
      end
      SchGreenBlue: begin
        if (seg == 2'd0) begin
          c.g = down; c.b = up;
        end else begin
          c.g = up; c.b = down;
        end
      end
      SchBlueRed: begin
        if (seg == 2'd0) begin
          c.r = up; c.b = down;
        end else begin
          c.r = down; c.b = up;
        end
      end
      default: begin
        if (seg == 2'd0) begin
          c.r = down; c.g = up;
        end else if (seg == 2'd1) begin
          c.g = down; c.b = up;
        end else begin
          c.b = down; c.r = up;
        end
      end
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/rbw_ctrl.sv
// Frame sequencer: walks the bulbs and steps the datapath through divide, load and send.
`default_nettype none
module rbw_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            in_tick_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire rbw_pkg::rbw_sts_t sts_i,
  output rbw_pkg::rbw_cmd_t    cmd_o
);
  import rbw_pkg::*;

  rbw_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_tick_i && !sts_i.n_zero) state_d = ST_PREP;
      end
      ST_PREP: state_d = sts_i.spread ? ST_DIV : ST_LOAD;
      ST_DIV: begin
        if (sts_i.div_done) state_d = ST_LOAD;
      end
      ST_LOAD: state_d = ST_SEND;
      ST_SEND: begin
        if (out_ready_i) state_d = sts_i.last ? ST_IDLE : ST_PREP;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o        = 1'b1;
        cmd_o.frame_start = in_valid_i && in_tick_i && !sts_i.n_zero;
        cmd_o.adv_phase   = in_valid_i && in_tick_i && sts_i.n_zero;
      end
      ST_PREP: cmd_o.div_init = sts_i.spread;
      ST_DIV:  cmd_o.div_step = 1'b1;
      ST_LOAD: cmd_o.load_out = 1'b1;
      ST_SEND: begin
        out_valid_o     = 1'b1;
        cmd_o.adv_phase = out_ready_i && sts_i.last;
        cmd_o.next_bulb = out_ready_i && !sts_i.last;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/rbw_dp.sv
// Datapath: config registers, bulb counter, phase, serial divider and colour output register.
`default_nettype none
module rbw_dp #(
  parameter int MAX_BULBS = rbw_pkg::DefMaxBulbs
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [rbw_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [rbw_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire rbw_pkg::rbw_cmd_t             cmd_i,
  output rbw_pkg::rbw_sts_t                  sts_o,
  output logic [rbw_pkg::OutDataW-1:0]       out_data_o,
  output logic                               out_last_o
);
  import rbw_pkg::*;

  localparam logic [CountW-1:0] MaxN = CountW'(MAX_BULBS);

  logic [ModeW-1:0]  mode_q;
  logic [CountW-1:0] count_q;
  logic [IdxW-1:0]   bulb_q;
  logic [PhaseW-1:0] phase_q;
  logic [DivW-1:0]   dq_q;
  logic [CountW-1:0] rem_q;
  logic [StepW-1:0]  step_q;
  logic [IdxW-1:0]   idx_out_q;
  rbw_rgb_t          rgb_q;
  logic              last_q;

  logic [ModeW-1:0]  mode_eff;
  logic [1:0]        scheme;
  logic [1:0]        variant;
  logic              wheel;
  logic [PhaseW-1:0] cycle;
  logic [CountW-1:0] n_sat;
  logic              last;
  logic [CountW-1:0] phase_inc;
  logic [CountW-1:0] trial;
  logic              fits;
  logic [PhaseW-1:0] base;
  logic [PhaseW-1:0] shift;
  logic [7:0]        sum;
  logic [PhaseW-1:0] pos;
  rbw_rgb_t          rgb;

  // mode 12..15 folds back onto 0..3
  assign mode_eff = (mode_q >= ModeCount) ? mode_q - ModeCount : mode_q;
  assign scheme   = mode_eff[1:0];
  assign variant  = mode_eff[3:2];
  assign wheel    = (scheme == SchWheel);
  assign cycle    = wheel ? WheelCycle : RampCycle;
  assign n_sat    = (count_q > MaxN) ? MaxN : count_q;
  assign last     = (({1'b0, bulb_q} + 7'd1) == n_sat);

  assign sts_o.spread   = (variant == VarSpread);
  assign sts_o.n_zero   = (n_sat == '0);
  assign sts_o.last     = last;
  assign sts_o.div_done = (step_q == DivLastStep);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= '0;
      count_q <= CountReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgRegMode:  mode_q  <= cfg_data_i[ModeW-1:0];
        CfgRegCount: count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign phase_inc = {1'b0, phase_q} + 7'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      bulb_q  <= '0;
    end else begin
      if (cmd_i.adv_phase) begin
        phase_q <= (phase_inc >= {1'b0, cycle}) ? '0 : phase_inc[PhaseW-1:0];
      end
      if (cmd_i.frame_start) begin
        bulb_q <= '0;
      end else if (cmd_i.next_bulb) begin
        bulb_q <= bulb_q + 6'd1;
      end
    end
  end

  // restoring divider, one quotient bit per cycle: bulb * cycle / n
  assign trial = {rem_q[CountW-2:0], dq_q[DivW-1]};
  assign fits  = (trial >= n_sat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.div_init) begin
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      step_q <= step_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      dq_q  <= DivW'(bulb_q * cycle);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dq_q  <= {dq_q[DivW-2:0], fits};
      rem_q <= fits ? trial - n_sat : trial;
    end
  end

  // ring position: sum stays below 135, so two subtracts cover mod 48
  always_comb begin
    base  = (variant == VarSpread) ? dq_q[PhaseW-1:0] : bulb_q;
    shift = '0;
    if (variant != VarOffset && variant != VarSpread && !bulb_q[0]) begin
      shift = cycle >> 1;
    end
    sum = {2'b00, base} + {2'b00, shift} + {2'b00, phase_q};
    if (!wheel) begin
      pos = {1'b0, sum[4:0]};
    end else if (sum >= 8'd96) begin
      pos = PhaseW'(sum - 8'd96);
    end else if (sum >= 8'd48) begin
      pos = PhaseW'(sum - 8'd48);
    end else begin
      pos = sum[PhaseW-1:0];
    end
    rgb = rbw_colour(scheme, pos);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      idx_out_q <= bulb_q;
      rgb_q     <= rgb;
      last_q    <= last;
    end
  end

  assign out_data_o = {6'b0, rgb_q.b, rgb_q.g, rgb_q.r, idx_out_q};
  assign out_last_o = last_q;

endmodule
`default_nettype wire

### hw/rtl/rainbow_pattern_generator.sv
// Top level of the rainbow pattern generator: stream ports, controller and datapath.
//
// Usage: each item on the slave stream is one frame request (tdata bit 0 = tick).
// A tick of one emits one colour item per bulb on the master stream, bulb 0 first,
// with tlast on the final bulb; a tick of zero is taken and ignored.
// The config port (cfg_we_i, cfg_idx_i, cfg_data_i) sets register 0 = pattern mode,
// register 1 = bulb count; write it only while the block is idle.
// Timing: a frame request is taken only when idle (s_axis_tready high). Each bulb
// passes through the states PREP, LOAD and SEND, plus receiver stall, in the offset and
// interlaced modes, and PREP, DIV, LOAD and SEND in the spread modes, where a 12-step
// restoring divider computes bulb*cycle/count. After a request is taken, the controller
// passes through these states for bulb 0 before tvalid rises and the first item goes out.
// The output register holds the item while the receiver stalls; nothing is dropped
// and the next bulb is computed only after the current item is taken. The phase
// advances once the last bulb is taken (at once for a bulb count of zero).
// Reset: mode 0, bulb count 50, phase 0, controller idle, no item pending.
`default_nettype none
module rainbow_pattern_generator #(
  parameter int MAX_BULBS = rbw_pkg::DefMaxBulbs
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [rbw_pkg::InDataW-1:0]   s_axis_tdata,   // [0] frame_tick
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [rbw_pkg::OutDataW-1:0]       m_axis_tdata,   // [5:0] bulb_index,
                                                             // [9:6] red, [13:10] green,
                                                             // [17:14] blue
  output logic                               m_axis_tlast,   // last_bulb
  input  wire logic                          cfg_we_i,
  input  wire logic [rbw_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [rbw_pkg::CfgDataW-1:0]  cfg_data_i
);
  import rbw_pkg::*;

  rbw_cmd_t cmd;
  rbw_sts_t sts;

  rbw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_tick_i   (s_axis_tdata[0]),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rbw_dp #(
    .MAX_BULBS (MAX_BULBS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (m_axis_tdata),
    .out_last_o (m_axis_tlast)
  );

  // no new frame while a colour item is pending
  a_valid_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("frame accepted while an item is pending");

  // the last bulb taken returns the block to idle
  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("block not idle after the last bulb");

  // a non-final bulb is followed by a compute gap before the next item
  a_gap_after_bulb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> !m_axis_tvalid && !s_axis_tready)
    else $error("next bulb shown without computing it");

  // bulb index stays below MAX_BULBS
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ({1'b0, m_axis_tdata[5:0]} < 7'(MAX_BULBS)))
    else $error("bulb index beyond the string");

endmodule
`default_nettype wire

### tb/rainbow_pattern_generator_tb.sv
// Self-checking testbench for the rainbow pattern generator: frame requests in, bulb colours checked.
module rainbow_pattern_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rbw_pkg::*;

  localparam int CycleLimit   = 4_000_000;
  // Long enough that a frame that emits nothing (count of zero) is surely
  // finished before a register write.
  localparam int SettleCycles = 40;
  localparam int RandomFrames = 190;
  localparam int CalmFrames   = 40;   // tail of the random part runs without stalls
  localparam int MaxPrinted   = 100;
  // third variant (mode / 4 == 2): even bulbs shifted by half a cycle
  localparam logic [1:0] VarInterlace = 2'd2;

  typedef struct packed {
    logic [IdxW-1:0]   idx;
    logic [LevelW-1:0] red;
    logic [LevelW-1:0] green;
    logic [LevelW-1:0] blue;
    logic              last;
  } bulb_colour_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;   // [0] frame_tick, rest zero
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;         // [5:0] bulb_index, [9:6] red,
                                             // [13:10] green, [17:14] blue
  logic                m_axis_tlast;         // last_bulb
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  // Our own copy of the block's registers and animation phase
  logic [ModeW-1:0]  mode_q  = '0;
  logic [CountW-1:0] count_q = CountReset;
  logic [PhaseW-1:0] phase_q = '0;

  bulb_colour_t pending_colours[$];   // colours still owed by the block, oldest first
  int unsigned  errors        = 0;
  int unsigned  cycles        = 0;
  bit           stalls_on     = 1'b1;
  int           rx_stall_left = 0;

  always #5 clk_i = ~clk_i;

  rainbow_pattern_generator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Colour prediction
  // ---------------------------------------------------------------------------

  // Position on the ramp or wheel -> levels. Each 16-step segment fades one
  // colour down while the next one comes up.
  function automatic bulb_colour_t colour_for(logic [1:0] scheme, int unsigned pos);
    bulb_colour_t      c;
    logic [LevelW-1:0] up;
    logic [LevelW-1:0] down;
    int unsigned       seg;
    seg  = pos / 16;
    up   = LevelW'(pos % 16);
    down = 4'd15 - up;
    c    = '0;
    case (scheme)
      SchRedGreen: begin
        if (seg == 0) begin
          c.red = down; c.green = up;
        end else begin
          c.red = up; c.green = down;
        end
      end
      SchGreenBlue: begin
        if (seg == 0) begin
          c.green = down; c.blue = up;
        end else begin
          c.green = up; c.blue = down;
        end
      end
      SchBlueRed: begin
        if (seg == 0) begin
          c.red = up; c.blue = down;
        end else begin
          c.red = down; c.blue = up;
        end
      end
      default: begin   // three-colour wheel, 48 positions
        if (seg == 0) begin
          c.red = down; c.green = up;
        end else if (seg == 1) begin
          c.green = down; c.blue = up;
        end else begin
          c.blue = down; c.red = up;
        end
      end
    endcase
    return c;
  endfunction

  // Queue the colours one accepted frame request owes and, for a tick of one, step the phase.
  function automatic void predict_frame(logic tick);
    int unsigned  mode;
    int unsigned  cyc;
    int unsigned  n;
    int unsigned  pos;
    int unsigned  shift;
    logic [1:0]   scheme;
    logic [1:0]   variant;
    bulb_colour_t c;
    if (!tick) return;   // a zero tick is swallowed, phase untouched
    mode    = mode_q % ModeCount;   // modes 12..15 alias onto 0..3
    scheme  = 2'(mode % 4);
    variant = 2'(mode / 4);
    cyc     = (scheme == SchWheel) ? WheelCycle : RampCycle;
    n       = (count_q > DefMaxBulbs) ? DefMaxBulbs : count_q;
    for (int unsigned i = 0; i < n; i++) begin
      case (variant)
        VarOffset: pos = (i + phase_q) % cyc;
        VarSpread: pos = ((i * cyc) / n + phase_q) % cyc;
        default: begin   // VarInterlace
          shift = (i % 2 == 0) ? cyc / 2 : 0;
          pos   = (i + shift + phase_q) % cyc;
        end
      endcase
      c      = colour_for(scheme, pos);
      c.idx  = IdxW'(i);
      c.last = (i + 1 == n);
      pending_colours.push_back(c);
    end
    // a phase left over from the wheel may already be past a ramp's cycle
    if (phase_q + 1 >= cyc) phase_q = '0;
    else phase_q = phase_q + 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (errors < MaxPrinted) $display("[%0t] MISMATCH %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk_i) begin : check_colours
    bulb_colour_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_colours.size() == 0) begin
        report_mismatch($sformatf("unexpected item for bulb %0d", m_axis_tdata[IdxW-1:0]));
      end else begin
        want = pending_colours.pop_front();
        if (m_axis_tdata[IdxW-1:0] !== want.idx)
          report_mismatch($sformatf("bulb index: got %0d, expected %0d",
                                    m_axis_tdata[IdxW-1:0], want.idx));
        if (m_axis_tdata[IdxW +: LevelW] !== want.red)
          report_mismatch($sformatf("bulb %0d red: got %0d, expected %0d",
                                    want.idx, m_axis_tdata[IdxW +: LevelW], want.red));
        if (m_axis_tdata[IdxW+LevelW +: LevelW] !== want.green)
          report_mismatch($sformatf("bulb %0d green: got %0d, expected %0d", want.idx,
                                    m_axis_tdata[IdxW+LevelW +: LevelW], want.green));
        if (m_axis_tdata[IdxW+2*LevelW +: LevelW] !== want.blue)
          report_mismatch($sformatf("bulb %0d blue: got %0d, expected %0d", want.idx,
                                    m_axis_tdata[IdxW+2*LevelW +: LevelW], want.blue));
        if (m_axis_tlast !== want.last)
          report_mismatch($sformatf("bulb %0d last flag: got %0b, expected %0b",
                                    want.idx, m_axis_tlast, want.last));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: back-pressure in random bursts of stalled cycles
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (rx_stall_left > 0) begin
      rx_stall_left--;
      m_axis_tready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 7) == 0) begin
      rx_stall_left = $urandom_range(0, 14);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one frame request; returns at the edge that takes it. tvalid stays
  // high so the next request can follow without a bubble.
  task automatic send_frame(input logic tick);
    int unsigned gap;
    @(negedge clk_i);
    gap = (stalls_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'(tick);
    do @(posedge clk_i); while (!s_axis_tready);
    predict_frame(tick);
  endtask

  // Stop sending, let every owed colour come out, then give the block time to
  // finish a frame that emits nothing.
  task automatic drain_and_settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_colours.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Register writes only ever happen with the block idle.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    drain_and_settle();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgRegMode) mode_q = value[ModeW-1:0];
    else count_q = value;
  endtask

  task automatic set_config(input logic [ModeW-1:0] mode, input logic [CountW-1:0] count);
    write_reg(CfgRegMode, CfgDataW'(mode));
    write_reg(CfgRegCount, count);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Register defaults: red-green ramp, 50 bulbs, phase zero
  task automatic test_reset_defaults();
    send_frame(1'b1);
  endtask

  // All twelve modes plus the four that alias back onto the first ones
  task automatic test_every_mode();
    write_reg(CfgRegCount, 7'd6);
    for (int m = 0; m < 16; m++) begin
      write_reg(CfgRegMode, CfgDataW'(m));
      send_frame(1'b1);
    end
  endtask

  // String length extremes
  task automatic test_bulb_counts();
    set_config(4'd7, 7'd64);    // wheel spread over a full string
    send_frame(1'b1);
    set_config(4'd4, 7'd127);   // saturates to the maximum, spread divisor too
    send_frame(1'b1);
    set_config(4'd11, 7'd1);    // single bulb, interlaced wheel
    send_frame(1'b1);
    set_config(4'd2, 7'd0);     // empty string: no colours, phase still moves
    send_frame(1'b1);
    send_frame(1'b1);
    write_reg(CfgRegCount, 7'd3);
    send_frame(1'b1);
  endtask

  // Zero ticks are taken and ignored; the frame after them shows the phase kept
  task automatic test_zero_tick();
    send_frame(1'b0);
    send_frame(1'b0);
    send_frame(1'b1);
  endtask

  // Run the wheel phase past the ramp cycle, then drop to a ramp mode
  task automatic test_stale_phase();
    set_config(4'd3, 7'd0);
    while (phase_q < 6'd44) send_frame(1'b1);
    set_config(4'd9, 7'd5);
    send_frame(1'b1);
    send_frame(1'b1);
  endtask

  // Random settings, each followed by a burst of frames
  task automatic test_random_frames();
    int unsigned      sent;
    int unsigned      burst;
    int unsigned      pick;
    logic [ModeW-1:0] mode;
    logic [CountW-1:0] count;
    sent = 0;
    while (sent < RandomFrames) begin
      if (sent >= RandomFrames - CalmFrames) stalls_on = 1'b0;
      // mostly short strings keep the run fast; long and oversized ones now and then
      pick = $urandom_range(0, 99);
      if (pick < 70) count = CountW'($urandom_range(1, 12));
      else if (pick < 88) count = CountW'($urandom_range(13, 64));
      else if (pick < 95) count = CountW'($urandom_range(65, 127));
      else count = '0;
      mode = ModeW'($urandom_range(0, 15));
      pick = $urandom_range(0, 3);
      // upper data bits of a mode write are junk the block must drop
      if (pick != 0) write_reg(CfgRegMode, {3'($urandom), mode});
      if (pick != 1) write_reg(CfgRegCount, count);
      burst = $urandom_range(2, 12);
      repeat (burst) begin
        if ($urandom_range(0, 9) == 0) begin
          send_frame(1'b0);
        end else begin
          send_frame(1'b1);
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_every_mode();
    test_bulb_counts();
    test_zero_tick();
    test_stale_phase();
    test_random_frames();

    drain_and_settle();
    if (errors == 0 && pending_colours.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
